// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the regulator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define DBR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Same-cycle implication.
`define DBR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define DBR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/dbr_pkg.sv =====
// ----------------------------------------------------------------------------
// dbr_pkg
// Types, constants and conversion helpers for the deadband duty regulator.
// ----------------------------------------------------------------------------
package dbr_pkg;

  localparam int DutyMaxDef  = 1024;
  localparam int AvgShiftDef = 8;

  localparam int AdcW      = 12;
  localparam int MvW       = 15;
  localparam int TimeW     = 32;
  localparam int AvgOutW   = 13;
  localparam int DutyOutW  = 11;
  localparam int TempW     = 8;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;

  localparam logic [MvW-1:0] PumpOnMv = MvW'(2500);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET_MV   = 3'd0,
    CFG_COARSE_BAND = 3'd1,
    CFG_FINE_BAND   = 3'd2,
    CFG_COARSE_STEP = 3'd3,
    CFG_FINE_STEP   = 3'd4,
    CFG_PERIOD_MS   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [13:0] target_mv;
    logic [11:0] coarse_band_mv;
    logic [11:0] fine_band_mv;
    logic [7:0]  coarse_step;
    logic [7:0]  fine_step;
    logic [15:0] update_period_ms;
  } cfg_t;

  typedef struct packed {
    logic [AdcW-1:0]  supply_adc;
    logic [AdcW-1:0]  outer_adc;
    logic [AdcW-1:0]  control_adc;
    logic [TimeW-1:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic [MvW-1:0]      supply_mv;
    logic [MvW-1:0]      control_mv;
    logic [AvgOutW-1:0]  outer_avg_out;
    logic [DutyOutW-1:0] duty_out;
    logic                duty_written;
    logic                update_taken;
    logic [TempW-1:0]    flow_temp;
    logic                pump_on;
  } result_t;

  // (adc + 14) * 1000 / 128 == (adc + 14) * 125 / 16
  function automatic logic [MvW-1:0] adc_to_mv(input logic [AdcW-1:0] adc);
    logic [12:0] s;
    logic [19:0] p;
    s = 13'(adc) + 13'd14;
    p = (20'(s) << 7) - (20'(s) << 2) + 20'(s);
    return p[18:4];
  endfunction

  // (mv + 6134) / 257: n >> 8 is the quotient or one above it
  function automatic logic [TempW-1:0] mv_to_temp(input logic [MvW-1:0] mv);
    logic [15:0] n;
    logic [7:0]  q0;
    logic [16:0] back;
    n    = 16'(mv) + 16'd6134;
    q0   = n[15:8];
    back = {1'b0, q0, 8'd0} + 17'(q0);
    return (back > 17'(n)) ? q0 - 8'd1 : q0;
  endfunction

endpackage

// ===== src/deadband_duty_regulator.sv =====
// ----------------------------------------------------------------------------
// deadband_duty_regulator
// Sample conversion, outer-sensor averaging and deadband duty regulation.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_stall_o is low and gives one result per
// item. An accepted item is held in the input register and its result then in
// the result register, from which it can be taken; an item leaves the input
// register only when the result register is free. Throughput is one item a
// cycle while the outputs do not stall, bounded by the update of the average,
// duty and last-update timestamp registers; the result register lets a new item
// in while the previous result is still stalled. Config writes are taken at any
// time (ready is tied high) but belong in idle periods. No start-up sweep.
`include "assert_macros.svh"

module deadband_duty_regulator
  import dbr_pkg::*;
#(
  parameter int DUTY_MAX  = DutyMaxDef,
  parameter int AVG_SHIFT = AvgShiftDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [AdcW-1:0]     supply_adc_i,
  input  logic [AdcW-1:0]     outer_adc_i,
  input  logic [AdcW-1:0]     control_adc_i,
  input  logic [TimeW-1:0]    now_ms_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [MvW-1:0]      supply_mv_o,
  output logic [MvW-1:0]      control_mv_o,
  output logic [AvgOutW-1:0]  outer_avg_out_o,
  output logic [DutyOutW-1:0] duty_out_o,
  output logic                duty_written_o,
  output logic                update_taken_o,
  output logic [TempW-1:0]    flow_temp_o,
  output logic                pump_on_o,

  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg;
  sample_t smp_q;
  result_t res, res_q;
  logic    smp_valid_q, smp_valid_d;
  logic    out_valid_q, out_valid_d;
  logic    out_free, smp_adv, in_take;

  dbr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign smp_adv    = smp_valid_q && out_free;
  assign in_stall_o = smp_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    smp_valid_d = smp_valid_q;
    if (in_take) begin
      smp_valid_d = 1'b1;
    end else if (smp_adv) begin
      smp_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (smp_adv) begin
      out_valid_d = 1'b1;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      smp_valid_q <= smp_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      smp_q.supply_adc  <= supply_adc_i;
      smp_q.outer_adc   <= outer_adc_i;
      smp_q.control_adc <= control_adc_i;
      smp_q.now_ms      <= now_ms_i;
    end
    if (smp_adv) begin
      res_q <= res;
    end
  end

  dbr_datapath #(
    .DUTY_MAX  (DUTY_MAX),
    .AVG_SHIFT (AVG_SHIFT)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (smp_adv),
    .sample_i  (smp_q),
    .cfg_i     (cfg),
    .result_o  (res)
  );

  assign out_valid_o     = out_valid_q;
  assign supply_mv_o     = res_q.supply_mv;
  assign control_mv_o    = res_q.control_mv;
  assign outer_avg_out_o = res_q.outer_avg_out;
  assign duty_out_o      = res_q.duty_out;
  assign duty_written_o  = res_q.duty_written;
  assign update_taken_o  = res_q.update_taken;
  assign flow_temp_o     = res_q.flow_temp;
  assign pump_on_o       = res_q.pump_on;

  // a stall upstream only ever comes from a full input stage behind a stalled result
  `DBR_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, smp_valid_q && out_valid_q)
  // an item leaving the input stage always lands in the result register
  `DBR_ASSERT_NXT(a_adv_lands, clk_i, rst_ni, smp_adv, out_valid_q)
  // a stalled result stays put
  `DBR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_q && out_stall_i, out_valid_q && $stable(res_q))

endmodule

// ===== src/dbr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dbr_cfg_regs
// Configuration register file with a simple valid/ready write port.
// ----------------------------------------------------------------------------
module dbr_cfg_regs
  import dbr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TARGET_MV:   cfg_d.target_mv        = cfg_data_i[13:0];
        CFG_COARSE_BAND: cfg_d.coarse_band_mv   = cfg_data_i[11:0];
        CFG_FINE_BAND:   cfg_d.fine_band_mv     = cfg_data_i[11:0];
        CFG_COARSE_STEP: cfg_d.coarse_step      = cfg_data_i[7:0];
        CFG_FINE_STEP:   cfg_d.fine_step        = cfg_data_i[7:0];
        CFG_PERIOD_MS:   cfg_d.update_period_ms = cfg_data_i;
        default:         cfg_d = cfg_q;  // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_mv        <= '0;
      cfg_q.coarse_band_mv   <= 12'd500;
      cfg_q.fine_band_mv     <= 12'd50;
      cfg_q.coarse_step      <= 8'd10;
      cfg_q.fine_step        <= 8'd1;
      cfg_q.update_period_ms <= 16'd100;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/dbr_datapath.sv =====
// ----------------------------------------------------------------------------
// dbr_datapath
// Per-item conversion, running average and duty regulation step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dbr_datapath
  import dbr_pkg::*;
#(
  parameter int DUTY_MAX  = DutyMaxDef,
  parameter int AVG_SHIFT = AvgShiftDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_en_i,
  input  sample_t sample_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  localparam int DutyW   = $clog2(DUTY_MAX + 1);
  localparam int SumW    = ((DutyW > 8) ? DutyW : 8) + 1;
  localparam int AvgW    = AdcW + AVG_SHIFT;
  localparam int AvgSumW = AvgW + 1;
  localparam int RndC    = 1 << (AVG_SHIFT - 1);
  localparam logic [DutyW-1:0] DutyMaxC = DutyW'(DUTY_MAX);

  logic [AvgW-1:0]    avg_q, avg_d;
  logic [DutyW-1:0]   duty_q, duty_d;
  logic [TimeW-1:0]   last_q, last_d;

  logic [MvW-1:0]     supply_mv, control_mv;
  logic [AvgSumW-1:0] avg_sum, avg_rnd;
  logic [TimeW-1:0]   elapsed;
  logic               taken, written;
  logic               up_coarse, up_fine, dn_coarse, dn_fine;
  logic [15:0]        tgt16, cm16;
  logic [7:0]         step_amt;
  logic               step_up;
  logic [SumW-1:0]    up_sum, dn_diff;
  logic [DutyW-1:0]   duty_adj;
  logic [31:0]        duty_wide;

  assign supply_mv  = adc_to_mv(sample_i.supply_adc);
  assign control_mv = adc_to_mv(sample_i.control_adc);

  // avg += outer - (avg >> shift); never leaves AvgW bits
  assign avg_sum = AvgSumW'(avg_q) + AvgSumW'(sample_i.outer_adc)
                 - AvgSumW'(avg_q >> AVG_SHIFT);
  assign avg_d   = avg_sum[AvgW-1:0];
  assign avg_rnd = AvgSumW'(avg_d) + AvgSumW'(RndC);

  assign elapsed = sample_i.now_ms - last_q;
  assign taken   = elapsed >= TimeW'(cfg_i.update_period_ms);

  assign tgt16 = 16'(cfg_i.target_mv);
  assign cm16  = 16'(control_mv);

  assign up_coarse = cm16 > tgt16 + 16'(cfg_i.coarse_band_mv);
  assign up_fine   = cm16 > tgt16 + 16'(cfg_i.fine_band_mv);
  assign dn_coarse = cm16 + 16'(cfg_i.coarse_band_mv) < tgt16;
  assign dn_fine   = cm16 + 16'(cfg_i.fine_band_mv) < tgt16;

  // priority: coarse up, fine up, coarse down, fine down
  always_comb begin
    written  = 1'b1;
    step_up  = 1'b1;
    step_amt = cfg_i.coarse_step;
    if (up_coarse) begin
      step_amt = cfg_i.coarse_step;
    end else if (up_fine) begin
      step_amt = cfg_i.fine_step;
    end else if (dn_coarse) begin
      step_up  = 1'b0;
      step_amt = cfg_i.coarse_step;
    end else if (dn_fine) begin
      step_up  = 1'b0;
      step_amt = cfg_i.fine_step;
    end else begin
      written  = 1'b0;
    end
  end

  assign up_sum  = SumW'(duty_q) + SumW'(step_amt);
  assign dn_diff = SumW'(duty_q) - SumW'(step_amt);

  always_comb begin
    if (step_up) begin
      duty_adj = (up_sum > SumW'(DUTY_MAX)) ? DutyMaxC : up_sum[DutyW-1:0];
    end else begin
      duty_adj = (SumW'(duty_q) > SumW'(step_amt)) ? dn_diff[DutyW-1:0] : '0;
    end
  end

  assign duty_d = (taken && written) ? duty_adj : duty_q;
  assign last_d = taken ? sample_i.now_ms : last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q  <= '0;
      duty_q <= DutyMaxC;
      last_q <= '0;
    end else if (step_en_i) begin
      avg_q  <= avg_d;
      duty_q <= duty_d;
      last_q <= last_d;
    end
  end

  assign duty_wide = 32'(duty_d);

  always_comb begin
    result_o.supply_mv     = supply_mv;
    result_o.control_mv    = control_mv;
    result_o.outer_avg_out = avg_rnd[AVG_SHIFT +: AvgOutW];
    result_o.duty_out      = duty_wide[DutyOutW-1:0];
    result_o.duty_written  = taken && written;
    result_o.update_taken  = taken;
    result_o.flow_temp     = mv_to_temp(control_mv);
    result_o.pump_on       = control_mv > PumpOnMv;
  end

  `DBR_ASSERT(a_duty_in_range, clk_i, rst_ni, duty_q <= DutyMaxC)
  `DBR_ASSERT_NXT(a_duty_holds, clk_i, rst_ni, step_en_i && !taken, $stable(duty_q))
  `DBR_ASSERT_IMP(a_written_needs_taken, clk_i, rst_ni, result_o.duty_written, taken)

endmodule
